// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== sv/mqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mqs_pkg
// Types and constants shared by the median/rank selector modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mqs_pkg;
    localparam int MAX_SAMPLES = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS    = 6;
    localparam int RANK_BITS   = 6;
    localparam int PADDR_BITS  = 3;

    localparam logic [PADDR_BITS-1:0] REG_USE_RANK = 3'd0;
    localparam logic [PADDR_BITS-1:0] REG_RANK     = 3'd4;

    typedef enum logic [2:0] {
        S_LOAD, S_CAND_RD, S_CAND_LD, S_SCAN_RD, S_SCAN_CMP, S_EVAL, S_OUT
    } mqs_state_t;

    typedef struct packed {
        logic load_wr;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_inc;
        logic rd_sel_j;
        logic cand_ld;
        logic cmp;
        logic eval;
        logic out_ld;
    } mqs_cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic out_free;
    } mqs_sts_t;
endpackage
`default_nettype wire

// ===== sv/mqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqs_ctrl
// Sequencer for loading the set and scanning it for the selected ranks.
// ----------------------------------------------------------------------------
`default_nettype none
module mqs_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    input  wire                s_tlast,
    output logic               s_tready,
    input  mqs_pkg::mqs_sts_t  sts,
    output mqs_pkg::mqs_cmd_t  cmd
);
    import mqs_pkg::*;

    mqs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast) begin
                        cmd.i_clr  = 1'b1;
                        state_next = S_CAND_RD;
                    end
                end
            end
            S_CAND_RD: begin
                state_next = S_CAND_LD;
            end
            S_CAND_LD: begin
                cmd.cand_ld = 1'b1;
                cmd.j_clr   = 1'b1;
                state_next  = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                cmd.rd_sel_j = 1'b1;
                state_next   = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                cmd.cmp    = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = sts.j_last ? S_EVAL : S_SCAN_RD;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                cmd.i_inc  = 1'b1;
                state_next = sts.i_last ? S_OUT : S_CAND_RD;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/mqs_dpath.sv =====
// ----------------------------------------------------------------------------
// mqs_dpath
// Sample store, rank counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mqs_dpath (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire signed [mqs_pkg::SAMPLE_BITS-1:0] sample,
    input  wire                                  use_rank,
    input  wire        [mqs_pkg::RANK_BITS-1:0]   rank,
    input  mqs_pkg::mqs_cmd_t                     cmd,
    output mqs_pkg::mqs_sts_t                     sts,
    input  wire                                  m_tready,
    output logic                                 m_tvalid,
    output logic signed [mqs_pkg::SAMPLE_BITS-1:0] value,
    output logic       [mqs_pkg::CNT_BITS-1:0]    set_size,
    output logic                                 error
);
    import mqs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] cand_reg, lo_reg, hi_reg;
    logic [CNT_BITS-1:0] cnt_reg, i_reg, j_reg, lt_reg, le_reg;
    logic                ovf_reg, m_tvalid_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [CNT_BITS-1:0]  k0, k1;
    logic                even, rank_err;
    logic signed [SAMPLE_BITS:0] sum;
    logic signed [SAMPLE_BITS:0] avg;

    assign rd_addr = cmd.rd_sel_j ? j_reg[ADDR_BITS-1:0] : i_reg[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && cnt_reg < CNT_BITS'(MAX_SAMPLES)) begin
            mem[cnt_reg[ADDR_BITS-1:0]] <= sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Zero-based target ranks; the second is used for an even-count median.
    assign k0       = use_rank ? rank - 1'b1 : (cnt_reg - 1'b1) >> 1;
    assign k1       = k0 + 1'b1;
    assign even     = !use_rank && !cnt_reg[0];
    assign rank_err = use_rank && (rank == '0 || rank > cnt_reg);
    assign sum      = {lo_reg[SAMPLE_BITS-1], lo_reg} + {hi_reg[SAMPLE_BITS-1], hi_reg};
    // Arithmetic halving rounds down; adding the sign bit first truncates toward zero.
    assign avg      = (sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]}) >>> 1;

    assign sts.i_last   = (i_reg == cnt_reg - 1'b1);
    assign sts.j_last   = (j_reg == cnt_reg - 1'b1);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_wr) begin
                if (cnt_reg < CNT_BITS'(MAX_SAMPLES)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.out_ld) begin
                cnt_reg      <= '0;
                ovf_reg      <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.i_clr) i_reg <= '0;
        else if (cmd.i_inc) i_reg <= i_reg + 1'b1;
        if (cmd.j_clr) j_reg <= '0;
        else if (cmd.j_inc) j_reg <= j_reg + 1'b1;
        if (cmd.cand_ld) begin
            cand_reg <= rd_data_reg;
            lt_reg   <= '0;
            le_reg   <= '0;
        end else if (cmd.cmp) begin
            if (rd_data_reg < cand_reg) lt_reg <= lt_reg + 1'b1;
            if (rd_data_reg <= cand_reg) le_reg <= le_reg + 1'b1;
        end
        if (cmd.eval) begin
            if (lt_reg <= k0 && k0 < le_reg) lo_reg <= cand_reg;
            if (lt_reg <= k1 && k1 < le_reg) hi_reg <= cand_reg;
        end
        if (cmd.out_ld) begin
            value    <= rank_err ? '0 : (even ? avg[SAMPLE_BITS-1:0] : lo_reg);
            set_size <= cnt_reg;
            error    <= rank_err || ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_BITS'(MAX_SAMPLES))
    `ASSERT_CLK(a_clear_after_out, aclk, aresetn, cmd.out_ld |=> cnt_reg == '0 && !ovf_reg)
    `ASSERT_CLK(a_lt_le, aclk, aresetn, $past(cmd.cmp) |-> lt_reg <= le_reg)
endmodule
`default_nettype wire

// ===== sv/median_quickselect_unit.sv =====
// A set of n samples loads at one beat per cycle while s_tready is high; the input
// is held off during selection, which is a ranking scan through the single read
// port of the sample store, and the result then goes to the output register.
// A new set is taken only once the previous result has entered that register.
// Reset (aresetn, synchronous, active low) empties the set, drops any pending
// result and sets use_rank to 0 and rank to 1.
// ----------------------------------------------------------------------------
// median_quickselect_unit
// Median or rank selector over a loaded set of signed samples.
// ----------------------------------------------------------------------------
`default_nettype none
module median_quickselect_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // APB-style configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    input  wire         s_tlast,   // last sample of the set
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [15:0] value, [21:16] set_size, [23:22] zero
    output logic        m_tuser    // [0] error
);
    import mqs_pkg::*;

    logic                 use_rank_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic                 wr_en;
    mqs_cmd_t             cmd;
    mqs_sts_t             sts;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CNT_BITS-1:0]  set_size;
    logic                 error;

    // Configuration registers. The write lands in the access phase; pready
    // is tied high so no access has wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_rank_reg <= 1'b0;
            rank_reg     <= RANK_BITS'(1);
        end else if (wr_en) begin
            case (paddr)
                REG_USE_RANK: use_rank_reg <= pwdata[0];
                REG_RANK:     rank_reg     <= pwdata[RANK_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_USE_RANK: prdata = {31'd0, use_rank_reg};
            REG_RANK:     prdata = {{(32-RANK_BITS){1'b0}}, rank_reg};
            default:      prdata = '0;
        endcase
    end

    // The controller sequences the load and the ranking scan; the datapath
    // holds the store, the counters and the output register.
    mqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mqs_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sample   (s_tdata),
        .use_rank (use_rank_reg),
        .rank     (rank_reg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .value    (value),
        .set_size (set_size),
        .error    (error)
    );

    assign m_tdata = {2'b00, set_size, value};
    assign m_tuser = error;
endmodule
`default_nettype wire
